// File: rtl/core/spe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_pkg: shared types and constants of the sentence payload extractor
// Byte codes, header patterns, sentence kinds and the four-byte number parser.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam logic [7:0] START_BYTE   = 8'h24;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] COMMA_BYTE   = 8'h2C;
    localparam logic [7:0] PLUS_BYTE    = 8'h2B;
    localparam logic [7:0] MINUS_BYTE   = 8'h2D;
    localparam logic [7:0] ZERO_BYTE    = 8'h30;
    localparam logic [7:0] NINE_BYTE    = 8'h39;
    localparam logic [7:0] SPACE_BYTE   = 8'h20;
    localparam logic [7:0] TAB_BYTE     = 8'h09;
    localparam logic [7:0] CR_BYTE      = 8'h0D;

    localparam int HDR_CHARS  = 6;
    localparam int LEN_W      = 14;
    localparam int COMMA_W    = 3;

    // Header patterns, first character in the most significant byte.
    localparam logic [8*HDR_CHARS-1:0] HDR_GGA = "$GPGGA";
    localparam logic [8*HDR_CHARS-1:0] HDR_IMU = "$GPIMU";
    localparam logic [8*HDR_CHARS-1:0] HDR_ROV = "$GPROV";
    localparam logic [8*HDR_CHARS-1:0] HDR_REF = "$GPREF";

    // The declared length counts the six header bytes plus the payload.
    localparam logic [LEN_W-1:0] LENGTH_OFFSET = LEN_W'(6);

    localparam logic [COMMA_W-1:0] COMMA_LOAD = COMMA_W'(3);
    localparam logic [COMMA_W-1:0] COMMA_CAP  = COMMA_W'(4);

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_GGA  = 3'd1,
        KIND_IMU  = 3'd2,
        KIND_ROV  = 3'd3,
        KIND_REF  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
    } spe_in_t;

    typedef struct packed {
        logic [2:0] sentence_kind;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       payload_last;
    } spe_out_t;

    typedef struct packed {
        logic             neg;
        logic [LEN_W-1:0] value;
    } number_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == SPACE_BYTE) || (c >= TAB_BYTE && c <= CR_BYTE);
    endfunction

    // Decimal parse of four bytes, oldest first: blanks, optional sign, digits.
    function automatic number_t parse_number(input logic [3:0][7:0] d);
        number_t    res;
        logic       started;
        logic       done;
        logic [7:0] c;
        res     = '0;
        started = 1'b0;
        done    = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            c = d[i];
            if (!done)
            begin
                if (!started && is_blank(c))
                begin
                    started = 1'b0;
                end
                else if (!started && (c == PLUS_BYTE || c == MINUS_BYTE))
                begin
                    res.neg = (c == MINUS_BYTE);
                    started = 1'b1;
                end
                else if (c >= ZERO_BYTE && c <= NINE_BYTE)
                begin
                    res.value = LEN_W'(res.value * LEN_W'(10))
                              + {{(LEN_W-4){1'b0}}, 4'(c - ZERO_BYTE)};
                    started = 1'b1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/spe_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_stream_if: valid/ready channel
// Carries one payload of the given type per transaction.
// ----------------------------------------------------------------------------
interface spe_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/sentence_payload_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sentence_payload_extractor_core: sentence classifier and payload extractor
// Path: an accepted byte waits in the input register, and its result is
//   held in the result register until the result channel takes it.
// Throughput: one byte per cycle while the result channel is not stalled.
// Reset: rst_n clears both stage valids and all sentence state; no sentence
//   is open after reset.
// ----------------------------------------------------------------------------
module sentence_payload_extractor_core
    import spe_pkg::*;
#(
    parameter int LENGTH_FIELD_LIMIT = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    spe_stream_if.sink   stream,
    spe_stream_if.source result
);

    localparam int POS_W = $clog2(LENGTH_FIELD_LIMIT + 4);
    localparam logic [POS_W-1:0] POS_CAP    = POS_W'(LENGTH_FIELD_LIMIT + 3);
    localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(LENGTH_FIELD_LIMIT + 2);
    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(HDR_CHARS);

    logic                 in_valid_reg;
    spe_in_t              in_data_reg;
    logic                 out_valid_reg;
    spe_out_t             out_data_reg;
    logic                 advance;

    logic [POS_W-1:0]     pos_reg,    pos_next;
    logic [4:0][7:0]      recent_reg;
    logic [2:0]           kind_reg,   kind_next;
    logic [COMMA_W-1:0]   commas_reg, commas_next;
    logic [LEN_W-1:0]     len_reg,    len_next;
    logic [LEN_W-1:0]     cnt_reg,    cnt_next;

    logic [7:0]           b;
    logic [8*HDR_CHARS-1:0] hdr;
    number_t              num;
    spe_out_t             res;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    assign b   = in_data_reg.in_byte;
    assign hdr = {recent_reg[4], recent_reg[3], recent_reg[2], recent_reg[1],
                  recent_reg[0], b};
    assign num = parse_number({recent_reg[1], recent_reg[2], recent_reg[3],
                               recent_reg[4]});

    // recent_reg[0] is always the previous byte of the stream.
    always_comb
    begin
        pos_next    = pos_reg;
        kind_next   = kind_reg;
        commas_next = commas_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        res         = '0;

        if (pos_reg == '0)
        begin
            if (b == START_BYTE && recent_reg[0] == NEWLINE_BYTE)
                pos_next = POS_W'(1);
        end
        else
        begin
            if (pos_reg < POS_CAP)
                pos_next = pos_reg + POS_W'(1);
            if (pos_next == POS_HEADER)
            begin
                if (hdr == HDR_GGA)
                    kind_next = KIND_GGA;
                else if (hdr == HDR_IMU)
                    kind_next = KIND_IMU;
                else if (hdr == HDR_ROV)
                    kind_next = KIND_ROV;
                else if (hdr == HDR_REF)
                    kind_next = KIND_REF;
                else
                begin
                    pos_next    = '0;
                    kind_next   = KIND_NONE;
                    commas_next = '0;
                    len_next    = '0;
                    cnt_next    = '0;
                end
            end
        end

        if (kind_next != KIND_NONE)
        begin
            res.sentence_kind = kind_next;
            if (kind_next == KIND_GGA || kind_next == KIND_IMU)
            begin
                if (b == NEWLINE_BYTE)
                begin
                    pos_next    = '0;
                    kind_next   = KIND_NONE;
                    commas_next = '0;
                    len_next    = '0;
                    cnt_next    = '0;
                end
            end
            else
            begin
                if (recent_reg[0] == COMMA_BYTE && commas_next < COMMA_CAP)
                    commas_next = commas_next + COMMA_W'(1);
                // The byte after the third comma loads the length field.
                if (len_next == '0 && commas_next == COMMA_LOAD)
                begin
                    if (pos_next > POS_LIMIT || num.neg || num.value <= LENGTH_OFFSET)
                    begin
                        pos_next    = '0;
                        kind_next   = KIND_NONE;
                        commas_next = '0;
                        len_next    = '0;
                        cnt_next    = '0;
                    end
                    else
                    begin
                        len_next = num.value - LENGTH_OFFSET;
                    end
                end
                if (len_next != '0)
                begin
                    cnt_next          = cnt_next + LEN_W'(1);
                    res.payload_valid = 1'b1;
                    res.payload_byte  = b;
                    if (cnt_next >= len_next)
                    begin
                        res.payload_last = 1'b1;
                        pos_next    = '0;
                        kind_next   = KIND_NONE;
                        commas_next = '0;
                        len_next    = '0;
                        cnt_next    = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            recent_reg    <= '0;
            kind_reg      <= KIND_NONE;
            commas_reg    <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (stream.valid && stream.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                pos_reg    <= pos_next;
                recent_reg <= {recent_reg[3:0], b};
                kind_reg   <= kind_next;
                commas_reg <= commas_next;
                len_reg    <= len_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
            in_data_reg <= stream.payload;
        if (advance)
            out_data_reg <= res;
    end

endmodule

// File: rtl/core/spe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_checker: port-level checks of the sentence payload extractor
// Watches the result channel and is bound to sentence_payload_extractor_core.
// ----------------------------------------------------------------------------
module spe_checker
    import spe_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input spe_out_t out_data
);

    // Outside payload bytes the byte and last flag read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.payload_valid |->
            out_data.payload_byte == 8'h00 && !out_data.payload_last)
        else $error("spe: payload fields set on a non-payload byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.payload_last |-> out_data.payload_valid)
        else $error("spe: last marked on a non-payload byte");

    // Only rover and reference sentences carry payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.payload_valid |->
            out_data.sentence_kind == KIND_ROV || out_data.sentence_kind == KIND_REF)
        else $error("spe: payload on a sentence kind without payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("spe: stalled result transaction changed");

endmodule

bind sentence_payload_extractor_core spe_checker u_spe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.payload)
);
